// File: hw/rtl/qfde_pkg.sv
`timescale 1ns / 1ps

package qfde_pkg;

	// field widths
	localparam int IDX_W  = 4;
	localparam int COEF_W = 16;
	localparam int VAL_W  = 16;
	localparam int DIFF_W = 17;
	localparam int DIMS_W = 5;
	localparam int SUM_W  = 56;
	localparam int TDATA_IN_W  = 56;
	localparam int TDATA_OUT_W = 56;

	// build defaults
	localparam int MAX_DIM_DEFAULT = 16;
	localparam int DIMS_RESET      = 16;

	// input item kinds
	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_ELEMENT = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load;   // write one matrix coefficient
		logic start;  // take an element: store difference, open its row pass
		logic issue;  // issue one multiply-accumulate of the row pass
		logic emit;   // move the sum to the output register and clear
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic has_work;   // element count below the active dimension count
		logic issue_end;  // current issue is the diagonal term
		logic pipe_busy;  // products still in flight
		logic out_free;   // output register can take a result
	} status_t;

endpackage

// File: hw/rtl/qfde_ctrl.sv
`timescale 1ns / 1ps

module qfde_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              action,
	input  logic              last,
	input  qfde_pkg::status_t status,
	output qfde_pkg::cmd_t    cmd
);
	import qfde_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   last_q;
	logic   accept;
	logic   is_elem;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign is_elem  = (action == ACT_ELEMENT);

	assign cmd.load  = accept && !is_elem;
	assign cmd.start = accept && is_elem && status.has_work;
	assign cmd.issue = (state_q == ST_RUN);
	assign cmd.emit  = (state_q == ST_EMIT) && status.out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_elem) begin
					if (status.has_work) begin
						state_d = ST_RUN;
					end else if (last) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_RUN: begin
				if (status.issue_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) begin
					state_d = last_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && is_elem) begin
				last_q <= last;
			end
		end
	end

	a_emit_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !status.pipe_busy)
		else $error("result taken while products in flight");

	a_no_accept_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> !in_ready)
		else $error("input ready during a row pass");

	a_run_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (state_q == ST_RUN))
		else $error("element start did not open a row pass");

endmodule

// File: hw/rtl/qfde_datapath.sv
`timescale 1ns / 1ps

module qfde_datapath #(
	parameter int MAX_DIM = qfde_pkg::MAX_DIM_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  qfde_pkg::cmd_t                      cmd,
	output qfde_pkg::status_t                   status,
	input  logic [qfde_pkg::IDX_W-1:0]          row_index,
	input  logic [qfde_pkg::IDX_W-1:0]          col_index,
	input  logic signed [qfde_pkg::COEF_W-1:0]  coefficient,
	input  logic signed [qfde_pkg::VAL_W-1:0]   x_value,
	input  logic signed [qfde_pkg::VAL_W-1:0]   y_value,
	input  logic                                cfg_wen,
	input  logic [qfde_pkg::DIMS_W-1:0]         cfg_wdata,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [qfde_pkg::SUM_W-1:0]   quadratic_distance
);
	import qfde_pkg::*;

	localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CW    = $clog2(MAX_DIM + 1);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RST_DIMS = (DIMS_RESET > MAX_DIM) ? MAX_DIM : DIMS_RESET;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int TERM_W = PROD_W + DIFF_W;

	logic signed [COEF_W-1:0] mat_mem [DEPTH];
	logic signed [DIFF_W-1:0] diff_mem [MAX_DIM];

	logic [CW-1:0] count_q;
	logic [CW-1:0] active_q;
	logic [CW-1:0] dims_clamped;
	logic [IW-1:0] n_q;
	logic [IW-1:0] j_q;
	logic signed [DIFF_W-1:0] dn_q;
	logic signed [DIFF_W-1:0] d_new;
	logic signed [SUM_W-1:0]  sum_q;

	logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
	logic          wr_ok;

	logic signed [COEF_W-1:0] ma_s1, mb_s1;
	logic signed [DIFF_W-1:0] dj_s1, dj_s2, dj_s3;
	logic signed [DIFF_W-1:0] c_s2;
	logic signed [PROD_W-1:0] p_s3;
	logic signed [TERM_W-1:0] t_s4;
	logic diag_s1;
	logic v_s1, v_s2, v_s3, v_s4;
	logic out_valid_q;
	logic signed [SUM_W-1:0] out_data_q;

	assign d_new = {x_value[VAL_W-1], x_value} - {y_value[VAL_W-1], y_value};

	assign wr_ok   = (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);
	assign wr_addr = AW'(int'(row_index) * MAX_DIM + int'(col_index));
	assign rd_addr_a = AW'(int'(n_q) * MAX_DIM + int'(j_q));
	assign rd_addr_b = AW'(int'(j_q) * MAX_DIM + int'(n_q));

	always_comb begin
		if (cfg_wdata == '0) begin
			dims_clamped = CW'(1);
		end else if (int'(cfg_wdata) > MAX_DIM) begin
			dims_clamped = CW'(MAX_DIM);
		end else begin
			dims_clamped = CW'(cfg_wdata);
		end
	end

	assign status.has_work  = (count_q < active_q);
	assign status.issue_end = (j_q == n_q);
	assign status.pipe_busy = v_s1 || v_s2 || v_s3 || v_s4;
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid          = out_valid_q;
	assign quadratic_distance = out_data_q;

	// coefficient and difference stores
	always_ff @(posedge clk) begin
		if (cmd.load && wr_ok) begin
			mat_mem[wr_addr] <= coefficient;
		end
		if (cmd.start) begin
			diff_mem[count_q[IW-1:0]] <= d_new;
		end
		ma_s1 <= mat_mem[rd_addr_a];
		mb_s1 <= mat_mem[rd_addr_b];
		dj_s1 <= diff_mem[j_q];
	end

	// product pipeline payload
	always_ff @(posedge clk) begin
		diag_s1 <= (j_q == n_q);
		if (diag_s1) begin
			c_s2 <= {ma_s1[COEF_W-1], ma_s1};
		end else begin
			c_s2 <= {ma_s1[COEF_W-1], ma_s1} + {mb_s1[COEF_W-1], mb_s1};
		end
		dj_s2 <= dj_s1;
		p_s3  <= dn_q * c_s2;
		dj_s3 <= dj_s2;
		t_s4  <= p_s3 * dj_s3;
		if (cmd.start) begin
			dn_q <= d_new;
			n_q  <= count_q[IW-1:0];
		end
		if (cmd.start) begin
			j_q <= '0;
		end else if (cmd.issue) begin
			j_q <= j_q + 1'b1;
		end
		if (cmd.emit) begin
			out_data_q <= sum_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			active_q    <= CW'(RST_DIMS);
			sum_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				active_q <= dims_clamped;
			end
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (cmd.emit) begin
				count_q <= '0;
				sum_q   <= '0;
			end else begin
				if (cmd.start) begin
					count_q <= count_q + 1'b1;
				end
				if (v_s4) begin
					sum_q <= sum_q + {{(SUM_W - TERM_W){t_s4[TERM_W-1]}}, t_s4};
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_issue_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (j_q <= n_q))
		else $error("column index ran past the diagonal");

	a_start_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> status.has_work)
		else $error("element started beyond the active dimensions");

	a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("pending result overwritten");

endmodule

// File: hw/rtl/quadratic_form_distance_engine.sv
`timescale 1ns / 1ps

// quadratic-form distance engine: computes (x-y)^T M (x-y) exactly. a load beat
// (tuser = 0) writes one signed Q1.14 coefficient M[row][col]; an element beat
// (tuser = 1) brings one x/y pair, and element n of a vector is folded in by a
// row pass of n+1 multiply-accumulates, one per cycle, reading M[n][j] and M[j][n]
// from the two read ports of the coefficient memory; the input is held off through
// the pass and the drain of a four-stage product pipeline. the beat with tlast set
// raises the 56-bit sum (14 fraction bits) through the emit state once its pass,
// if any, has drained, which holds the input off during that state as well, and
// restarts the vector; the result waits in an output register while loads of the
// next vector go on, and a still-full output register stretches the emit state.
// differences are read only after they were written; coefficients must be written
// before an element reads them, which the block itself does not enforce; the
// dimension count may only be changed while idle.
module quadratic_form_distance_engine #(
	parameter int MAX_DIM = qfde_pkg::MAX_DIM_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input beats
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// row_index[3:0], col_index[7:4], coefficient[23:8], x_value[39:24],
	// y_value[55:40]
	input  logic [qfde_pkg::TDATA_IN_W-1:0]       s_tdata,
	// action[0]
	input  logic                                  s_tuser,
	input  logic                                  s_tlast,
	// result beats
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// quadratic_distance[55:0]
	output logic [qfde_pkg::TDATA_OUT_W-1:0]      m_tdata,
	// dimension count register
	input  logic                                  cfg_wen,
	input  logic [qfde_pkg::DIMS_W-1:0]           cfg_wdata
);
	import qfde_pkg::*;

	cmd_t    cmd;
	status_t status;

	// unpacked input fields
	logic [IDX_W-1:0]         row_index;
	logic [IDX_W-1:0]         col_index;
	logic signed [COEF_W-1:0] coefficient;
	logic signed [VAL_W-1:0]  x_value;
	logic signed [VAL_W-1:0]  y_value;
	logic signed [SUM_W-1:0]  quadratic_distance;

	assign row_index   = s_tdata[3:0];
	assign col_index   = s_tdata[7:4];
	assign coefficient = s_tdata[23:8];
	assign x_value     = s_tdata[39:24];
	assign y_value     = s_tdata[55:40];

	assign m_tdata = quadratic_distance;

	// sequencer: accepts beats, runs the row pass, drains, emits
	qfde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.action   (s_tuser),
		.last     (s_tlast),
		.status   (status),
		.cmd      (cmd)
	);

	// stores, product pipeline, accumulator and output register
	qfde_datapath #(
		.MAX_DIM (MAX_DIM)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.status             (status),
		.row_index          (row_index),
		.col_index          (col_index),
		.coefficient        (coefficient),
		.x_value            (x_value),
		.y_value            (y_value),
		.cfg_wen            (cfg_wen),
		.cfg_wdata          (cfg_wdata),
		.out_valid          (m_tvalid),
		.out_ready          (m_tready),
		.quadratic_distance (quadratic_distance)
	);

endmodule

// File: dv/tb_quadratic_form_distance_engine.sv
`timescale 1ns / 1ps

module tb_quadratic_form_distance_engine;
	import qfde_pkg::*;

	localparam int DIMS          = MAX_DIM_DEFAULT;
	// settling time that covers any pass still running
	localparam int SETTLE_CYCLES = 48;
	localparam int MAX_GAP       = 24;
	localparam int RUN_LIMIT_NS  = 1_000_000;

	// beat layout of s_tdata
	localparam int ROW_LSB  = 0;
	localparam int COL_LSB  = 4;
	localparam int COEF_LSB = 8;
	localparam int X_LSB    = 24;
	localparam int Y_LSB    = 40;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    s_tvalid  = 1'b0;
	logic                    s_tready;
	// row_index[3:0], col_index[7:4], coefficient[23:8], x_value[39:24], y_value[55:40]
	logic [TDATA_IN_W-1:0]   s_tdata   = '0;
	// action[0]
	logic                    s_tuser   = ACT_LOAD;
	logic                    s_tlast   = 1'b0;
	logic                    m_tvalid;
	logic                    m_tready  = 1'b0;
	// quadratic_distance[55:0]
	logic [TDATA_OUT_W-1:0]  m_tdata;
	logic                    cfg_wen   = 1'b0;
	logic [DIMS_W-1:0]       cfg_wdata = '0;

	// idle mix, in cycles per hundred
	int send_idle_pct = 16;
	int recv_idle_pct = 66;

	// shadow of the block: coefficients, differences, running sum, dimension register
	logic signed [COEF_W-1:0] coef_mem [DIMS*DIMS];
	longint                   diff_mem [DIMS];
	int                       elem_count;
	logic [SUM_W-1:0]         sum_acc;
	logic [DIMS_W-1:0]        dims_reg;
	logic [SUM_W-1:0]         pending_distances [$];

	int mismatch_count    = 0;
	int distances_checked = 0;
	int items_sent        = 0;
	int loads_sent        = 0;
	int elements_sent     = 0;
	int settings_used     = 0;

	quadratic_form_distance_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	// result side: every accepted beat against the oldest pending distance
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_distances.size() == 0) begin
				report_mismatch($sformatf("distance %h with none pending", m_tdata));
			end else begin
				logic [SUM_W-1:0] want;
				want = pending_distances.pop_front();
				distances_checked++;
				if (m_tdata[SUM_W-1:0] !== want)
					report_mismatch($sformatf("quadratic_distance got %h want %h",
						m_tdata[SUM_W-1:0], want));
			end
		end
	end

	// zero acts as one, anything above the build size acts as the build size
	function automatic int active_dims();
		if (dims_reg == 0)
			return 1;
		if (dims_reg > DIMS)
			return DIMS;
		return int'(dims_reg);
	endfunction

	// folds one accepted beat into the shadow and queues the distance on a last mark
	task automatic track_quadratic_form(input logic act, input logic [TDATA_IN_W-1:0] data,
			input logic last);
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [VAL_W-1:0] xv;
		logic signed [VAL_W-1:0] yv;
		int                      n;
		int                      j;
		longint                  d;
		longint                  inner;
		row = data[ROW_LSB +: IDX_W];
		col = data[COL_LSB +: IDX_W];
		xv  = data[X_LSB +: VAL_W];
		yv  = data[Y_LSB +: VAL_W];
		if (act == ACT_LOAD) begin
			// last mark has no meaning on a load
			coef_mem[row*DIMS + col] = data[COEF_LSB +: COEF_W];
			loads_sent++;
			return;
		end
		elements_sent++;
		// elements past the active count add nothing
		if (elem_count < active_dims()) begin
			n = elem_count;
			d = longint'(xv) - longint'(yv);
			inner = d * longint'(coef_mem[n*DIMS + n]);
			for (j = 0; j < n; j++)
				inner += diff_mem[j] * (longint'(coef_mem[n*DIMS + j]) +
					longint'(coef_mem[j*DIMS + n]));
			diff_mem[n] = d;
			sum_acc = sum_acc + SUM_W'(d * inner);
			elem_count = n + 1;
		end
		if (last) begin
			pending_distances.push_back(sum_acc);
			sum_acc = '0;
			elem_count = 0;
		end
	endtask

	// valid is only lowered when a gap is drawn, so back-to-back beats keep it high
	task automatic send_beat(input logic act, input logic [TDATA_IN_W-1:0] data,
			input logic last);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= data;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		track_quadratic_form(act, data, last);
	endtask

	function automatic logic [TDATA_IN_W-1:0] pack_beat(input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col, input logic [COEF_W-1:0] coef,
			input logic [VAL_W-1:0] xv, input logic [VAL_W-1:0] yv);
		return {yv, xv, coef, col, row};
	endfunction

	// full-range word with the corners drawn often
	function automatic logic [15:0] pick_word();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'hffff;
			3: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// unused fields of a load carry random bits
	task automatic send_load(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
			input logic [COEF_W-1:0] coef, input logic last);
		send_beat(ACT_LOAD, pack_beat(row, col, coef, 16'($urandom), 16'($urandom)), last);
	endtask

	task automatic send_element(input logic [VAL_W-1:0] xv, input logic [VAL_W-1:0] yv,
			input logic last);
		send_beat(ACT_ELEMENT,
			pack_beat(4'($urandom), 4'($urandom), 16'($urandom), xv, yv), last);
	endtask

	// hold the input until every pending distance is out and the datapath has settled
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_distances.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_dims(input logic [DIMS_W-1:0] value);
		drain_results();
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		dims_reg = value;
		settings_used++;
	endtask

	// every coefficient gets written before any element reads it; then one full
	// vector at the dimension count left by reset
	task automatic test_fill_at_reset_dims();
		int r;
		int c;
		int i;
		for (r = 0; r < DIMS; r++)
			for (c = 0; c < DIMS; c++)
				send_load(IDX_W'(r), IDX_W'(c), pick_word(), 1'($urandom_range(1)));
		for (i = 0; i < DIMS; i++)
			send_element(16'h7fff, 16'h8000, i == DIMS - 1);
	endtask

	task automatic test_directed_corners();
		// one dimension, largest differences of both signs against the coefficient corners
		write_dims(5'd1);
		send_load(4'd0, 4'd0, 16'h8000, 1'b1);
		send_element(16'h7fff, 16'h8000, 1'b1);
		send_load(4'd0, 4'd0, 16'h7fff, 1'b0);
		send_element(16'h8000, 16'h7fff, 1'b1);
		send_load(4'd15, 4'd15, 16'h8000, 1'b1);
		send_load(4'd15, 4'd0, 16'h7fff, 1'b0);
		send_load(4'd0, 4'd15, 16'h0000, 1'b0);
		// zero acts as one; the two extra elements add nothing, the last mark still ends
		write_dims(5'd0);
		send_element(16'h7fff, 16'h7fff, 1'b0);
		send_element(16'h8000, 16'h0000, 1'b0);
		send_element(16'h0001, 16'hffff, 1'b1);
		// above the build size clamps; last mark before the vector is complete
		write_dims(5'd31);
		send_element(16'h7fff, 16'h8000, 1'b0);
		send_element(16'h8000, 16'h7fff, 1'b1);
		send_element(16'h1234, 16'hedcc, 1'b1);
		write_dims(5'd17);
		send_element(16'hffff, 16'h0001, 1'b0);
		send_element(16'h5555, 16'haaaa, 1'b0);
		send_element(16'haaaa, 16'h5555, 1'b1);
	endtask

	function automatic logic [DIMS_W-1:0] pick_dims();
		case ($urandom_range(9))
			0: return 5'd1;
			1: return 5'd16;
			2: return 5'd0;
			3: return DIMS_W'($urandom_range(17, 31));
			default: return DIMS_W'($urandom_range(1, 16));
		endcase
	endfunction

	// mostly complete vectors, some cut short, some with surplus elements, loads mixed in
	task automatic send_random_vector();
		int lim;
		int count;
		int kind;
		int i;
		lim = active_dims();
		repeat ($urandom_range(0, 3))
			send_load(4'($urandom), 4'($urandom), pick_word(), 1'($urandom_range(1)));
		kind = $urandom_range(9);
		if (kind == 0 && lim > 1)
			count = $urandom_range(1, lim - 1);
		else if (kind == 1)
			count = lim + $urandom_range(1, 3);
		else
			count = lim;
		for (i = 0; i < count; i++) begin
			if ($urandom_range(9) == 0)
				send_load(4'($urandom), 4'($urandom), pick_word(), 1'($urandom_range(1)));
			send_element(pick_word(), pick_word(), i == count - 1);
		end
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct,
			input int item_goal);
		int start;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		start = items_sent;
		while (items_sent - start < item_goal) begin
			write_dims(pick_dims());
			repeat ($urandom_range(2, 5)) begin
				send_random_vector();
				// sender holds off now and then until every distance is out
				if ($urandom_range(7) == 0)
					drain_results();
			end
		end
	endtask

	initial begin
		dims_reg   = DIMS_W'(DIMS_RESET);
		elem_count = 0;
		sum_acc    = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_at_reset_dims();
		test_directed_corners();
		test_random_traffic(16, 66, 240);
		test_random_traffic(66, 16, 240);
		test_random_traffic(0, 0, 240);
		drain_results();
		$display("run: %0d coefficient loads, %0d element beats, %0d dimension settings",
			loads_sent, elements_sent, settings_used);
		$display("run: %0d distances compared under both stall mixes and a stall-free stretch",
			distances_checked);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("TB_ERROR");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/qfde_pkg.sv
hw/rtl/qfde_ctrl.sv
hw/rtl/qfde_datapath.sv
hw/rtl/quadratic_form_distance_engine.sv
dv/tb_quadratic_form_distance_engine.sv
